/* design/osc_color_reply_parser_macros.svh */
// ----------------------------------------------------------------------------
// osc_color_reply_parser_macros.svh
// Assertion macros shared by the color reply parser RTL. Both sample on the
// rising edge of clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef OSC_COLOR_REPLY_PARSER_MACROS_SVH
`define OSC_COLOR_REPLY_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCRP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ocrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OCRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ocrp assertion failed");

`endif

/* design/ocrp_pkg.sv */
// ----------------------------------------------------------------------------
// ocrp_pkg
// Types, character codes and the channel scaling function of the color
// reply parser.
// ----------------------------------------------------------------------------
package ocrp_pkg;

   // Largest number of hex digits in one color channel.
   localparam int MAX_HEX_DIGITS = 4;

   // Characters of the reply grammar.
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_1     = 8'h31;
   localparam logic [7:0] CHR_4     = 8'h34;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_SEMI  = 8'h3B;
   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_R     = 8'h72;
   localparam logic [7:0] CHR_G     = 8'h67;
   localparam logic [7:0] CHR_B     = 8'h62;
   localparam logic [7:0] CHR_LA    = 8'h61;
   localparam logic [7:0] CHR_LF    = 8'h66;
   localparam logic [7:0] CHR_UA    = 8'h41;
   localparam logic [7:0] CHR_UF    = 8'h46;

   // Selector register codes for the default colors.
   localparam logic [8:0] SEL_FOREGROUND = 9'h1FF;
   localparam logic [8:0] SEL_BACKGROUND = 9'h1FE;

   // Parse state carried from one byte to the next.
   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  lit_pos;
      logic [7:0]  index_acc;
      logic        index_seen;
      logic [15:0] chan_acc;
      logic [2:0]  hex_cnt;
      logic [1:0]  chan_num;
      logic [7:0]  red;
      logic [7:0]  green;
      logic        err;
   } parse_state_type;

   // Start of a payload: selector phase, everything else zero.
   localparam parse_state_type PARSE_IDLE = '0;

   // Scale an n-digit hex channel to 8 bits: (v*255 + m/2) / m, m = 16^n - 1.
   // One digit reduces to v*17 and two digits to v. For three and four digits
   // the quotient by 2^k - 1 is the high part plus one correction step.
   function automatic logic [7:0] scale_chan(input logic [15:0] v,
                                             input logic [2:0]  n);
      logic [20:0] x3;
      logic [12:0] r3;
      logic [8:0]  q3;
      logic [23:0] x4;
      logic [16:0] r4;
      logic [8:0]  q4;
      logic [7:0]  res;
      x3 = {1'b0, v[11:0], 8'h00} - {9'h000, v[11:0]} + 21'd2047;
      r3 = {1'b0, x3[11:0]} + {4'h0, x3[20:12]};
      q3 = x3[20:12] + ((r3 >= 13'd4095) ? 9'd1 : 9'd0);
      x4 = {v, 8'h00} - {8'h00, v} + 24'd32767;
      r4 = {1'b0, x4[15:0]} + {9'h000, x4[23:16]};
      q4 = {1'b0, x4[23:16]} + ((r4 >= 17'd65535) ? 9'd1 : 9'd0);
      case (n)
         3'd2:    res = v[7:0];
         3'd3:    res = q3[7:0];
         3'd4:    res = q4[7:0];
         default: res = {v[3:0], v[3:0]};
      endcase
      return res;
   endfunction

endpackage

/* design/osc_color_reply_parser.sv */
// ----------------------------------------------------------------------------
// osc_color_reply_parser
// Byte-serial parser for the payload of a terminal color-query reply. It
// checks the selector echo against the configured query, reads "rgb:" and
// three hex channels, and gives ok or error with the packed color on the
// last byte of each payload.
//
//   channel | ports   | direction | contents
//   --------+---------+-----------+------------------------------------------
//   req     | req_t*  | in        | reply byte (tdata), last byte (tlast)
//   rsp     | rsp_t*  | out       | color (tdata), parse status (tuser)
//   csr     | csr_*   | in        | expected selector, 9-bit signed
//
// One byte is taken every cycle unless a last byte waits on a full result
// register. Each byte passes through the input register and is parsed from
// there into the state and result registers.
// Only a last byte needs the result register; other bytes pass while a
// result waits to be taken. Reset is synchronous and clears the parse state
// and sets the selector to the default foreground.
// ----------------------------------------------------------------------------
`include "osc_color_reply_parser_macros.svh"

module osc_color_reply_parser
   import ocrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Requests: reply bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] reply_byte
   input  logic        req_tlast,   // last_byte
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] color_rgb
   output logic        rsp_tuser,   // parse_status
   // Selector register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   // Parse phase codes.
   localparam logic [1:0] PH_SELECTOR = 2'd0;
   localparam logic [1:0] PH_INDEX    = 2'd1;
   localparam logic [1:0] PH_RGB      = 2'd2;
   localparam logic [1:0] PH_CHANNEL  = 2'd3;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic [8:0]      selector_ff;
   parse_state_type state_ff;
   parse_state_type parse_next;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   logic            status_ff;
   logic [23:0]     color_ff;
   logic            status_in;
   logic [23:0]     color_in;

   logic            proc_fire;
   logic            is_default;
   logic [7:0]      sel_want;
   logic [1:0]      sel_end;
   logic [7:0]      rgb_want;
   logic            is_dec;
   logic [11:0]     index_sum;
   logic            index_match;
   logic            is_hex;
   logic [3:0]      hex_val;
   logic [7:0]      chan_scaled;
   logic [7:0]      blue_scaled;

   // Handshakes: the input register moves on unless a last byte finds the
   // result register still full.
   assign proc_fire  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = color_ff;
   assign rsp_tuser  = status_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Selector register.
   always_ff @(posedge clock) begin
      if (reset) begin
         selector_ff <= SEL_FOREGROUND;
      end else if (csr_valid && csr_ready) begin
         selector_ff <= csr_data;
      end
   end

   // Expected characters of the selector echo and the rgb literal.
   assign is_default = (selector_ff == SEL_FOREGROUND) || (selector_ff == SEL_BACKGROUND);
   assign sel_end    = is_default ? 2'd2 : 2'd1;

   always_comb begin
      case (state_ff.lit_pos)
         2'd0:    sel_want = is_default ? CHR_1 : CHR_4;
         2'd1:    sel_want = is_default ? ((selector_ff == SEL_FOREGROUND) ? CHR_0 : CHR_1)
                                        : CHR_SEMI;
         default: sel_want = CHR_SEMI;
      endcase
   end

   always_comb begin
      case (state_ff.lit_pos)
         2'd0:    rgb_want = CHR_R;
         2'd1:    rgb_want = CHR_G;
         2'd2:    rgb_want = CHR_B;
         default: rgb_want = CHR_COLON;
      endcase
   end

   // Decimal index digit and its running value.
   assign is_dec      = (in_byte_ff >= CHR_0) && (in_byte_ff <= CHR_9);
   assign index_sum   = {1'b0, state_ff.index_acc, 3'b000} + {3'b000, state_ff.index_acc, 1'b0}
                        + {8'h00, in_byte_ff[3:0]};
   assign index_match = !selector_ff[8] && (state_ff.index_acc == selector_ff[7:0]);

   // Hex digit decode; letters carry 9 on top of their low nibble.
   always_comb begin
      if ((in_byte_ff >= CHR_0) && (in_byte_ff <= CHR_9)) begin
         is_hex  = 1'b1;
         hex_val = in_byte_ff[3:0];
      end else if (((in_byte_ff >= CHR_LA) && (in_byte_ff <= CHR_LF)) ||
                   ((in_byte_ff >= CHR_UA) && (in_byte_ff <= CHR_UF))) begin
         is_hex  = 1'b1;
         hex_val = in_byte_ff[3:0] + 4'd9;
      end else begin
         is_hex  = 1'b0;
         hex_val = 4'd0;
      end
   end

   // Scaling of the channel closed by a slash.
   assign chan_scaled = scale_chan(state_ff.chan_acc, state_ff.hex_cnt);

   // Parse step for the byte in the input register. Once an error is seen
   // the state holds until the last byte.
   always_comb begin
      parse_next = state_ff;
      if (!state_ff.err) begin
         case (state_ff.phase)
            PH_SELECTOR: begin
               if (in_byte_ff != sel_want) begin
                  parse_next.err = 1'b1;
               end else if (state_ff.lit_pos == sel_end) begin
                  parse_next.lit_pos = 2'd0;
                  parse_next.phase   = is_default ? PH_RGB : PH_INDEX;
               end else begin
                  parse_next.lit_pos = state_ff.lit_pos + 2'd1;
               end
            end
            PH_INDEX: begin
               if (is_dec) begin
                  if (index_sum > 12'd255) begin
                     parse_next.err = 1'b1;
                  end else begin
                     parse_next.index_acc  = index_sum[7:0];
                     parse_next.index_seen = 1'b1;
                  end
               end else if (in_byte_ff == CHR_SEMI) begin
                  if (!state_ff.index_seen || !index_match) begin
                     parse_next.err = 1'b1;
                  end else begin
                     parse_next.lit_pos = 2'd0;
                     parse_next.phase   = PH_RGB;
                  end
               end else begin
                  parse_next.err = 1'b1;
               end
            end
            PH_RGB: begin
               if (in_byte_ff != rgb_want) begin
                  parse_next.err = 1'b1;
               end else if (state_ff.lit_pos == 2'd3) begin
                  parse_next.lit_pos = 2'd0;
                  parse_next.phase   = PH_CHANNEL;
               end else begin
                  parse_next.lit_pos = state_ff.lit_pos + 2'd1;
               end
            end
            default: begin
               if (is_hex) begin
                  if (state_ff.hex_cnt >= 3'(MAX_HEX_DIGITS)) begin
                     parse_next.err = 1'b1;
                  end else begin
                     parse_next.chan_acc = {state_ff.chan_acc[11:0], hex_val};
                     parse_next.hex_cnt  = state_ff.hex_cnt + 3'd1;
                  end
               end else if (in_byte_ff == CHR_SLASH) begin
                  if ((state_ff.hex_cnt == 3'd0) || (state_ff.chan_num >= 2'd2)) begin
                     parse_next.err = 1'b1;
                  end else begin
                     if (state_ff.chan_num == 2'd0) begin
                        parse_next.red = chan_scaled;
                     end else begin
                        parse_next.green = chan_scaled;
                     end
                     parse_next.chan_num = state_ff.chan_num + 2'd1;
                     parse_next.chan_acc = 16'h0000;
                     parse_next.hex_cnt  = 3'd0;
                  end
               end else begin
                  parse_next.err = 1'b1;
               end
            end
         endcase
      end
   end

   // Result of a payload ending with this byte.
   assign blue_scaled = scale_chan(parse_next.chan_acc, parse_next.hex_cnt);

   always_comb begin
      if (!parse_next.err && (parse_next.phase == PH_CHANNEL) &&
          (parse_next.chan_num == 2'd2) && (parse_next.hex_cnt != 3'd0)) begin
         status_in = 1'b0;
         color_in  = {parse_next.red, parse_next.green, blue_scaled};
      end else begin
         status_in = 1'b1;
         color_in  = 24'h000000;
      end
   end

   assign state_in = in_last_ff ? PARSE_IDLE : parse_next;

   // Parse state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_IDLE;
      end else if (proc_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (proc_fire && in_last_ff) begin
         status_ff <= status_in;
         color_ff  <= color_in;
      end
   end

   // An error result never carries a color.
   `OCRP_ASSERT_SAME(a_error_no_color, rsp_valid_ff && status_ff, color_ff == 24'h000000)
   // A waiting result is never overwritten by the next payload.
   `OCRP_ASSERT_SAME(a_no_overwrite, rsp_valid_ff && !rsp_tready, !(proc_fire && in_last_ff))
   // After a last byte the parser starts over cleanly.
   `OCRP_ASSERT_NEXT(a_restart, proc_fire && in_last_ff, state_ff == PARSE_IDLE)
   // A byte held in the input register stays until it is parsed.
   `OCRP_ASSERT_NEXT(a_input_held, !req_tready, $stable({in_valid_ff, in_byte_ff, in_last_ff}))
   // The digit count never passes its limit.
   `OCRP_ASSERT_SAME(a_digit_limit, 1'b1, state_ff.hex_cnt <= 3'(MAX_HEX_DIGITS))

endmodule
